FILE: rtl/core/sjgl_pkg.sv
// Shared types and codes for the Shift-JIS glyph locator.
package sjgl_pkg;

   localparam int COORD_BITS_DEFAULT = 16;

   localparam logic [12:0] WINDOW_HEIGHT_RESET = 13'd400;

   localparam logic [1:0] STATUS_GLYPH = 2'd0;
   localparam logic [1:0] STATUS_ERROR = 2'd1;
   localparam logic [1:0] STATUS_END   = 2'd2;

   localparam logic [4:0] WIDTH_SINGLE = 5'd8;
   localparam logic [4:0] WIDTH_DOUBLE = 5'd16;

   typedef struct packed {
      logic [7:0]         code_byte;
      logic               new_string;
      logic signed [15:0] start_x;
      logic signed [15:0] start_y;
      logic [15:0]        max_chars;
      logic               upper_left;
   } req_type;

   typedef struct packed {
      logic [10:0]        glyph_x;
      logic [10:0]        glyph_y;
      logic [4:0]         glyph_width;
      logic signed [15:0] screen_x;
      logic signed [15:0] screen_y;
      logic [1:0]         status;
   } rsp_type;

endpackage

FILE: rtl/core/sjgl_parser.sv
// String state, Shift-JIS decode and atlas/pen computation for one byte.
module sjgl_parser #(
   parameter int COORD_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  sjgl_pkg::req_type req,
   input  logic [12:0]       window_height,
   output logic              rsp_hit,
   output sjgl_pkg::rsp_type rsp
);
   import sjgl_pkg::*;

   localparam int CW = COORD_BITS;
   localparam int WB = ((CW > 18) ? CW : 18) + 2;

   localparam logic signed [WB-1:0] SAT_HI = {{(WB-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [WB-1:0] SAT_LO = {{(WB-CW+1){1'b1}}, {(CW-1){1'b0}}};
   localparam logic signed [WB-1:0] GLYPH_H = {{(WB-5){1'b0}}, 5'd16};

   localparam logic [7:0]  LEAD_LO1   = 8'h81;
   localparam logic [7:0]  LEAD_HI1   = 8'h9F;
   localparam logic [7:0]  LEAD_LO2   = 8'hE0;
   localparam logic [7:0]  LEAD_HI2   = 8'hFC;
   localparam logic [7:0]  LEAD_FOLD  = 8'h40;
   localparam logic [7:0]  TRAIL_LO   = 8'h40;
   localparam logic [7:0]  TRAIL_GAP  = 8'h7F;
   localparam logic [7:0]  TRAIL_HI   = 8'hFC;
   localparam logic [7:0]  TRAIL_ROW2 = 8'h9E;
   localparam logic [7:0]  TRAIL_FOLD = 8'h5E;
   localparam logic [11:0] CELL_X_BASE = 12'd16;
   localparam logic [11:0] CELL_Y_BASE = 12'd528;
   localparam logic [11:0] ATLAS_TOP   = 12'd2032;

   function automatic logic signed [CW-1:0] sat(input logic signed [WB-1:0] v);
      logic signed [CW-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[CW-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[CW-1:0];
      end else begin
         r = v[CW-1:0];
      end
      return r;
   endfunction

   logic [7:0]           lead_ff, lead_in;
   logic                 pending_ff, pending_in;
   logic signed [CW-1:0] pen_x_ff, pen_x_in;
   logic signed [CW-1:0] pen_y_ff, pen_y_in;
   logic [15:0]          chars_ff, chars_in;
   logic                 stopped_ff, stopped_in;

   logic [7:0]           e_lead;
   logic                 e_pending;
   logic signed [CW-1:0] e_pen_x, e_pen_y;
   logic [15:0]          e_chars;
   logic                 e_stopped;

   logic signed [WB-1:0] sx_w, sy_w, wh_w, flip_w, px_w, py_w;
   logic [7:0]           b, t1, t2, l1, lrow, toff;
   logic [11:0]          cx, cy, gy2;
   logic                 bad_trail, good_lead;

   always_comb begin
      b = req.code_byte;
      sx_w = {{(WB-16){req.start_x[15]}}, req.start_x};
      sy_w = {{(WB-16){req.start_y[15]}}, req.start_y};
      wh_w = {{(WB-13){1'b0}}, window_height};
      flip_w = wh_w - GLYPH_H - sy_w;

      e_lead = lead_ff;
      e_pending = pending_ff;
      e_pen_x = pen_x_ff;
      e_pen_y = pen_y_ff;
      e_chars = chars_ff;
      e_stopped = stopped_ff;
      if (req.new_string) begin
         e_lead = 8'd0;
         e_pending = 1'b0;
         e_pen_x = sat(sx_w);
         e_pen_y = sat(req.upper_left ? flip_w : sy_w);
         e_chars = req.max_chars;
         e_stopped = 1'b0;
      end

      px_w = {{(WB-CW){e_pen_x[CW-1]}}, e_pen_x};
      py_w = {{(WB-CW){e_pen_y[CW-1]}}, e_pen_y};

      // two-byte code to atlas cell
      t1 = (b > TRAIL_GAP) ? b - 8'd1 : b;
      l1 = (e_lead >= LEAD_LO2) ? e_lead - LEAD_FOLD : e_lead;
      lrow = l1 - LEAD_LO1;
      cx = CELL_X_BASE + {1'b0, lrow[5:0], 5'd0};
      t2 = t1;
      if (t1 >= TRAIL_ROW2) begin
         cx = cx + 12'd16;
         t2 = t1 - TRAIL_FOLD;
      end
      toff = t2 - TRAIL_LO;
      cy = CELL_Y_BASE + {1'b0, toff[6:0], 4'd0};
      gy2 = ATLAS_TOP - cy;

      bad_trail = (b < TRAIL_LO) || (b > TRAIL_HI) || (b == TRAIL_GAP);
      good_lead = ((b >= LEAD_LO1) && (b <= LEAD_HI1)) ||
                  ((b >= LEAD_LO2) && (b <= LEAD_HI2));

      lead_in = e_lead;
      pending_in = e_pending;
      pen_x_in = e_pen_x;
      pen_y_in = e_pen_y;
      chars_in = e_chars;
      stopped_in = e_stopped;

      rsp_hit = 1'b0;
      rsp.glyph_x = 11'd0;
      rsp.glyph_y = 11'd0;
      rsp.glyph_width = 5'd0;
      rsp.screen_x = px_w[15:0];
      rsp.screen_y = py_w[15:0];
      rsp.status = STATUS_GLYPH;

      if (!e_stopped && (e_chars != 16'd0)) begin
         if (e_pending) begin
            pending_in = 1'b0;
            rsp_hit = 1'b1;
            if (bad_trail) begin
               rsp.status = STATUS_ERROR;
               stopped_in = 1'b1;
            end else begin
               rsp.glyph_x = cx[10:0];
               rsp.glyph_y = gy2[10:0];
               rsp.glyph_width = WIDTH_DOUBLE;
               pen_x_in = sat(px_w + {{(WB-5){1'b0}}, WIDTH_DOUBLE});
               chars_in = e_chars - 16'd1;
            end
         end else if (b == 8'd0) begin
            rsp_hit = 1'b1;
            rsp.status = STATUS_END;
            stopped_in = 1'b1;
         end else if (!b[7]) begin
            rsp_hit = 1'b1;
            rsp.glyph_x = {b[7:0], 3'd0};
            rsp.glyph_y = ATLAS_TOP[10:0];
            rsp.glyph_width = WIDTH_SINGLE;
            pen_x_in = sat(px_w + {{(WB-5){1'b0}}, WIDTH_SINGLE});
            chars_in = e_chars - 16'd1;
         end else if (good_lead) begin
            lead_in = b;
            pending_in = 1'b1;
         end else begin
            rsp_hit = 1'b1;
            rsp.status = STATUS_ERROR;
            stopped_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff <= 8'd0;
         pending_ff <= 1'b0;
         pen_x_ff <= '0;
         pen_y_ff <= '0;
         chars_ff <= 16'd0;
         stopped_ff <= 1'b1;
      end else if (fire) begin
         lead_ff <= lead_in;
         pending_ff <= pending_in;
         pen_x_ff <= pen_x_in;
         pen_y_ff <= pen_y_in;
         chars_ff <= chars_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

FILE: rtl/core/sjis_glyph_locator_stream_core.sv
// Top level: input register, parser, result register and window height CSR.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  code byte and string start fields
//   rsp      out        rsp_valid / rsp_stall  atlas texel, width, screen pos, status
//   csr      in         csr_wr_en              window height (13 bits)
//
// One byte per cycle when rsp_stall allows; a byte goes via input and result registers.
// Bytes that give no result (held lead, stopped string, limit reached) leave nothing.
// Reset is synchronous and leaves the string stopped until a new_string byte.
// req_stall rises only while the result register holds an untaken transaction.
module sjis_glyph_locator_stream_core #(
   parameter int COORD_BITS = sjgl_pkg::COORD_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_code_byte,
   input  logic               req_new_string,
   input  logic signed [15:0] req_start_x,
   input  logic signed [15:0] req_start_y,
   input  logic [15:0]        req_max_chars,
   input  logic               req_upper_left,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [10:0]        rsp_glyph_x,
   output logic [10:0]        rsp_glyph_y,
   output logic [4:0]         rsp_glyph_width,
   output logic signed [15:0] rsp_screen_x,
   output logic signed [15:0] rsp_screen_y,
   output logic [1:0]         rsp_status,

   input  logic               csr_wr_en,
   input  logic [12:0]        csr_wr_data
);
   import sjgl_pkg::*;

   logic        in_valid_ff, in_valid_in;
   req_type     in_req_ff;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_rsp_ff;
   logic [12:0] window_height_ff;

   logic        out_free, fire, req_take, hit;
   rsp_type     rsp_next;

   assign out_free = ~out_valid_ff | ~rsp_stall;
   assign fire = in_valid_ff & out_free;
   assign req_stall = in_valid_ff & ~out_free;
   assign req_take = req_valid & ~req_stall;

   assign in_valid_in = req_take | (in_valid_ff & ~fire);
   assign out_valid_in = (fire & hit) | (out_valid_ff & rsp_stall);

   sjgl_parser #(
      .COORD_BITS(COORD_BITS)
   ) u_parser (
      .clock(clock),
      .reset(reset),
      .fire(fire),
      .req(in_req_ff),
      .window_height(window_height_ff),
      .rsp_hit(hit),
      .rsp(rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         window_height_ff <= WINDOW_HEIGHT_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            window_height_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_req_ff.code_byte <= req_code_byte;
         in_req_ff.new_string <= req_new_string;
         in_req_ff.start_x <= req_start_x;
         in_req_ff.start_y <= req_start_y;
         in_req_ff.max_chars <= req_max_chars;
         in_req_ff.upper_left <= req_upper_left;
      end
      if (fire & hit) begin
         out_rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_glyph_x = out_rsp_ff.glyph_x;
   assign rsp_glyph_y = out_rsp_ff.glyph_y;
   assign rsp_glyph_width = out_rsp_ff.glyph_width;
   assign rsp_screen_x = out_rsp_ff.screen_x;
   assign rsp_screen_y = out_rsp_ff.screen_y;
   assign rsp_status = out_rsp_ff.status;

endmodule

FILE: tb/sv/tb_top.sv
// Testbench for the Shift-JIS glyph locator: directed and random strings, local predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sjgl_pkg::*;

   localparam int COORD_HI = (1 << (COORD_BITS_DEFAULT - 1)) - 1;
   localparam int COORD_LO = -COORD_HI - 1;
   localparam int IDLE_LIMIT = 5000;
   localparam int PHASE_BYTES = 320;

   localparam logic [7:0] NUL_BYTE   = 8'h00;
   localparam logic [7:0] ASCII_TOP  = 8'h7f;
   localparam logic [7:0] LEAD_A_LO  = 8'h81;
   localparam logic [7:0] LEAD_A_HI  = 8'h9f;
   localparam logic [7:0] LEAD_B_LO  = 8'he0;
   localparam logic [7:0] LEAD_B_HI  = 8'hfc;
   localparam logic [7:0] TRAIL_LO   = 8'h40;
   localparam logic [7:0] TRAIL_HOLE = 8'h7f;
   localparam logic [7:0] TRAIL_HI   = 8'hfc;
   localparam logic [7:0] TRAIL_ROW2 = 8'h9e;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_code_byte = '0;
   logic               req_new_string = 1'b0;
   logic signed [15:0] req_start_x = '0;
   logic signed [15:0] req_start_y = '0;
   logic [15:0]        req_max_chars = '0;
   logic               req_upper_left = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [10:0]        rsp_glyph_x;
   logic [10:0]        rsp_glyph_y;
   logic [4:0]         rsp_glyph_width;
   logic signed [15:0] rsp_screen_x;
   logic signed [15:0] rsp_screen_y;
   logic [1:0]         rsp_status;
   logic               csr_wr_en = 1'b0;
   logic [12:0]        csr_wr_data = '0;

   // predictor state
   logic [12:0] win_height = WINDOW_HEIGHT_RESET;
   logic [7:0]  held_lead = '0;
   bit          lead_pending = 1'b0;
   int          pen_x = 0;
   int          pen_y = 0;
   logic [15:0] chars_left = '0;
   bit          stopped = 1'b1;
   rsp_type     expected_glyphs[$];

   // current string start fields
   logic signed [15:0] str_x, str_y;
   logic [15:0]        str_max;
   bit                 str_ul;
   bit                 str_first = 1'b0;

   bit pacing = 1'b1;
   int bytes_sent = 0;
   int live_bytes = 0;
   int heights_used = 1;
   int mismatches = 0;
   int n_glyph = 0, n_error = 0, n_end = 0;
   int idle_cycles = 0;

   sjis_glyph_locator_stream_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_code_byte(req_code_byte), .req_new_string(req_new_string),
      .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_max_chars(req_max_chars), .req_upper_left(req_upper_left),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_glyph_x(rsp_glyph_x), .rsp_glyph_y(rsp_glyph_y),
      .rsp_glyph_width(rsp_glyph_width),
      .rsp_screen_x(rsp_screen_x), .rsp_screen_y(rsp_screen_y),
      .rsp_status(rsp_status),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int idle_len();
      int r;
      if (!pacing) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic int clamp_coord(int v);
      if (v > COORD_HI) return COORD_HI;
      if (v < COORD_LO) return COORD_LO;
      return v;
   endfunction

   function automatic void push_result(int gx, int gy, logic [4:0] w, logic [1:0] st);
      rsp_type e;
      e.glyph_x = 11'(gx);
      e.glyph_y = 11'(gy);
      e.glyph_width = w;
      e.screen_x = 16'(pen_x);
      e.screen_y = 16'(pen_y);
      e.status = st;
      expected_glyphs.push_back(e);
   endfunction

   function automatic void emit_glyph(int gx, int gy, logic [4:0] w);
      push_result(gx, gy, w, STATUS_GLYPH);
      pen_x = clamp_coord(pen_x + int'(w));
      chars_left--;
   endfunction

   function automatic void stop_string(logic [1:0] st);
      push_result(0, 0, '0, st);
      stopped = 1'b1;
      lead_pending = 1'b0;
   endfunction

   function automatic void locate_glyph(req_type r);
      int y, l, t, cx, cy;
      if (r.new_string) begin
         y = int'($signed(r.start_y));
         if (r.upper_left) y = int'(win_height) - 16 - y;
         pen_x = clamp_coord(int'($signed(r.start_x)));
         pen_y = clamp_coord(y);
         chars_left = r.max_chars;
         lead_pending = 1'b0;
         held_lead = '0;
         stopped = 1'b0;
      end
      if (stopped || chars_left == 0) return;
      live_bytes++;
      if (lead_pending) begin
         lead_pending = 1'b0;
         t = r.code_byte;
         l = held_lead;
         if (t < TRAIL_LO || t > TRAIL_HI || t == TRAIL_HOLE) begin
            stop_string(STATUS_ERROR);
            return;
         end
         if (t > TRAIL_HOLE) t--;
         if (l >= LEAD_B_LO) l -= 'h40;
         cx = 16 + (l - LEAD_A_LO) * 32;
         if (t >= TRAIL_ROW2) begin
            cx += 16;
            t -= 'h5e;
         end
         cy = 528 + (t - TRAIL_LO) * 16;
         emit_glyph(cx, 2032 - cy, WIDTH_DOUBLE);
      end else if (r.code_byte == NUL_BYTE) begin
         stop_string(STATUS_END);
      end else if (r.code_byte <= ASCII_TOP) begin
         emit_glyph(8 * r.code_byte, 2032, WIDTH_SINGLE);
      end else if ((r.code_byte >= LEAD_A_LO && r.code_byte <= LEAD_A_HI) ||
                   (r.code_byte >= LEAD_B_LO && r.code_byte <= LEAD_B_HI)) begin
         held_lead = r.code_byte;
         lead_pending = 1'b1;
      end else begin
         stop_string(STATUS_ERROR);
      end
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 30)
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : rsp_checker
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_glyphs.size() == 0) begin
            mismatches++;
            if (mismatches <= 30)
               $display("%0t: unexpected transaction, expected none actual status %0d",
                        $time, rsp_status);
         end else begin
            want = expected_glyphs.pop_front();
            check_field("glyph_x", want.glyph_x, rsp_glyph_x);
            check_field("glyph_y", want.glyph_y, rsp_glyph_y);
            check_field("glyph_width", want.glyph_width, rsp_glyph_width);
            check_field("screen_x", want.screen_x, rsp_screen_x);
            check_field("screen_y", want.screen_y, rsp_screen_y);
            check_field("status", want.status, rsp_status);
            case (want.status)
               STATUS_GLYPH: n_glyph++;
               STATUS_ERROR: n_error++;
               default: n_end++;
            endcase
         end
      end
   end

   initial begin : rsp_pacer
      int run;
      forever begin
         @(negedge clock);
         run = idle_len();
         if (run > 0) begin
            rsp_stall <= 1'b1;
            repeat (run) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                  $time, IDLE_LIMIT, expected_glyphs.size());
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic drive_byte(input req_type r);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_code_byte <= r.code_byte;
      req_new_string <= r.new_string;
      req_start_x <= r.start_x;
      req_start_y <= r.start_y;
      req_max_chars <= r.max_chars;
      req_upper_left <= r.upper_left;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      locate_glyph(r);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic begin_string(input logic signed [15:0] x, input logic signed [15:0] y,
                               input logic [15:0] max, input bit ul);
      str_x = x;
      str_y = y;
      str_max = max;
      str_ul = ul;
      str_first = 1'b1;
   endtask

   task automatic feed_byte(input logic [7:0] code);
      req_type r;
      r.code_byte = code;
      r.new_string = str_first;
      r.start_x = str_first ? str_x : 16'($urandom);
      r.start_y = str_first ? str_y : 16'($urandom);
      r.max_chars = str_first ? str_max : 16'($urandom);
      r.upper_left = str_first ? str_ul : 1'($urandom_range(0, 1));
      str_first = 1'b0;
      drive_byte(r);
   endtask

   // idle: every expected result taken and the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_glyphs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_window_height(input logic [12:0] h);
      csr_wr_en <= 1'b1;
      csr_wr_data <= h;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      win_height = h;
      heights_used++;
   endtask

   function automatic logic [7:0] rand_lead();
      if ($urandom_range(0, 1)) return 8'($urandom_range(LEAD_A_LO, LEAD_A_HI));
      return 8'($urandom_range(LEAD_B_LO, LEAD_B_HI));
   endfunction

   function automatic logic [7:0] rand_trail();
      logic [7:0] t;
      t = 8'($urandom_range(TRAIL_LO, TRAIL_HI));
      return (t == TRAIL_HOLE) ? TRAIL_LO : t;
   endfunction

   function automatic logic [7:0] bad_lead();
      case ($urandom_range(0, 2))
         0: return 8'h80;
         1: return 8'($urandom_range('ha0, 'hdf));
         default: return 8'($urandom_range('hfd, 'hff));
      endcase
   endfunction

   function automatic logic [7:0] bad_trail();
      case ($urandom_range(0, 2))
         0: return 8'($urandom_range(0, 'h3f));
         1: return TRAIL_HOLE;
         default: return 8'($urandom_range('hfd, 'hff));
      endcase
   endfunction

   task automatic random_string();
      int len, r;
      r = $urandom_range(0, 9);
      begin_string((r == 0) ? 16'(COORD_HI - $urandom_range(0, 300)) : 16'($urandom),
                   16'($urandom), '0, 1'($urandom_range(0, 1)));
      r = $urandom_range(0, 99);
      if (r < 4) str_max = '0;
      else if (r < 80) str_max = 16'($urandom_range(1, 24));
      else if (r < 92) str_max = 16'($urandom_range(25, 300));
      else str_max = 16'($urandom);
      len = $urandom_range(1, 20);
      if ($urandom_range(0, 99) < 8) begin
         repeat (len) feed_byte(8'($urandom));
         return;
      end
      repeat (len) begin
         if ($urandom_range(0, 2) == 0) begin
            feed_byte(rand_lead());
            feed_byte(rand_trail());
         end else begin
            feed_byte(8'($urandom_range(1, ASCII_TOP)));
         end
      end
      r = $urandom_range(0, 99);
      if (r < 70) begin
         feed_byte(NUL_BYTE);
      end else if (r < 78) begin
         feed_byte(bad_lead());
      end else if (r < 88) begin
         feed_byte(rand_lead());
         feed_byte(bad_trail());
      end else if (r < 94) begin
         feed_byte(rand_lead());
      end
   endtask

   task automatic test_single_byte();
      begin_string(16'sd32760, 16'sd100, 16'd100, 1'b0);
      feed_byte(ASCII_TOP);
      feed_byte(8'h01);
      feed_byte(NUL_BYTE);
   endtask

   task automatic test_double_byte();
      begin_string(-16'sd32768, 16'sd32767, 16'hffff, 1'b1);
      feed_byte(LEAD_A_LO);
      feed_byte(TRAIL_LO);
      feed_byte(LEAD_A_HI);
      feed_byte(8'h7e);
      feed_byte(LEAD_B_LO);
      feed_byte(TRAIL_ROW2);
      feed_byte(LEAD_B_HI);
      feed_byte(TRAIL_HI);
   endtask

   task automatic test_bad_codes();
      begin_string(16'sd0, 16'sd0, 16'd10, 1'b0);
      feed_byte(8'h80);
      feed_byte(8'h41);
      begin_string(16'sd7, -16'sd7, 16'd10, 1'b0);
      feed_byte(8'hff);
      begin_string(16'sd9, 16'sd9, 16'd10, 1'b0);
      feed_byte(8'h88);
      feed_byte(TRAIL_HOLE);
      begin_string(16'sd11, 16'sd11, 16'd10, 1'b1);
      feed_byte(8'h88);
      feed_byte(NUL_BYTE);
   endtask

   task automatic test_char_limit();
      begin_string(16'sd1, 16'sd1, 16'd0, 1'b0);
      feed_byte(NUL_BYTE);
      begin_string(16'sd2, 16'sd2, 16'd1, 1'b0);
      feed_byte(8'h41);
      feed_byte(8'h42);
      begin_string(16'sd3, 16'sd3, 16'd1, 1'b0);
      feed_byte(8'h82);
      feed_byte(8'h50);
      feed_byte(NUL_BYTE);
   endtask

   task automatic test_window_height();
      settle();
      set_window_height(13'd1);
      begin_string(16'sd5, -16'sd32768, 16'd5, 1'b1);
      feed_byte(8'h41);
      settle();
      set_window_height(13'd8191);
      begin_string(16'sd5, -16'sd32768, 16'd5, 1'b1);
      feed_byte(8'h41);
      settle();
      set_window_height(13'd4096);
      begin_string(16'sd5, 16'sd32767, 16'd5, 1'b1);
      feed_byte(8'h41);
      settle();
      set_window_height(13'd0);
      begin_string(16'sd5, 16'sd32767, 16'd5, 1'b1);
      feed_byte(8'h41);
      settle();
   endtask

   task automatic test_random_strings(input logic [12:0] h, input bit paced);
      int goal;
      settle();
      set_window_height(h);
      pacing = paced;
      goal = bytes_sent + PHASE_BYTES;
      while (bytes_sent < goal) random_string();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_single_byte();
      test_double_byte();
      test_bad_codes();
      test_char_limit();
      test_window_height();
      test_random_strings(WINDOW_HEIGHT_RESET, 1'b0);
      test_random_strings(13'd1, 1'b1);
      test_random_strings(13'd4096, 1'b1);
      test_random_strings(13'd8191, 1'b1);
      test_random_strings(13'd0, 1'b1);
      test_random_strings(13'($urandom_range(1, 4096)), 1'b1);
      settle();
      repeat (8) @(posedge clock);
      $display("Sent %0d bytes (%0d not ignored) under %0d window heights.",
               bytes_sent, live_bytes, heights_used);
      $display("Checked %0d glyphs, %0d code errors, %0d string ends; %0d mismatches.",
               n_glyph, n_error, n_end, mismatches);
      if (mismatches == 0 && expected_glyphs.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: sjis_glyph_locator_stream_core.f
rtl/core/sjgl_pkg.sv
rtl/core/sjgl_parser.sv
rtl/core/sjis_glyph_locator_stream_core.sv
tb/sv/tb_top.sv
